[rtl/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared sizes, codes, controller states and command/status structures.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(16);
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
    localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_COMMIT
    } lkv_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic fetch;
        logic commit;
    } lkv_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } lkv_status_t;

endpackage

[rtl/lkv_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Carries one get or put command per beat.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [lkv_pkg::DATA_W-1:0]    key;
    logic signed [lkv_pkg::DATA_W-1:0]    value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

[rtl/lkv_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Carries one result per beat.
// ----------------------------------------------------------------------------
interface lkv_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic signed [lkv_pkg::DATA_W-1:0]    read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

[rtl/lkv_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the capacity register write data, one write per beat.
// ----------------------------------------------------------------------------
interface lkv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lkv_pkg::CAP_W-1:0]      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/lkv_ctrl.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Sequences accept, key scan, value fetch and commit for one request.
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lkv_pkg::lkv_status_t status,
    output lkv_pkg::lkv_cmd_t    cmd
);

    lkv_pkg::lkv_state_t state_reg;
    lkv_pkg::lkv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = lkv_pkg::ST_FETCH;
                end
            end
            lkv_pkg::ST_FETCH:
            begin
                state_next = lkv_pkg::ST_COMMIT;
            end
            lkv_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            lkv_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            lkv_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            lkv_pkg::ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/lkv_datapath.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Key and value memories, valid bits, recency ranks, scan trackers,
// capacity register and the result register.
// ----------------------------------------------------------------------------
module lkv_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lkv_pkg::lkv_cmd_t                 cmd,
    output lkv_pkg::lkv_status_t              status,
    input  logic                              in_command,
    input  logic signed [lkv_pkg::DATA_W-1:0] in_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] in_value,
    input  logic                              cfg_valid,
    input  logic [lkv_pkg::CAP_W-1:0]         cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_found,
    output logic signed [lkv_pkg::DATA_W-1:0] out_read_value
);

    localparam int ENTRIES = lkv_pkg::ENTRIES;
    localparam int IDX_W   = lkv_pkg::IDX_W;
    localparam int RANK_W  = lkv_pkg::RANK_W;
    localparam int CNT_W   = lkv_pkg::CNT_W;
    localparam int CMP_W   = lkv_pkg::CMP_W;
    localparam int DATA_W  = lkv_pkg::DATA_W;

    logic [DATA_W-1:0] key_mem [ENTRIES];
    logic [DATA_W-1:0] val_mem [ENTRIES];

    logic [ENTRIES-1:0]      valid_reg;
    logic [ENTRIES-1:0]      valid_next;
    logic [RANK_W-1:0]       rank_reg  [ENTRIES];
    logic [RANK_W-1:0]       rank_next [ENTRIES];
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;
    logic [lkv_pkg::CAP_W-1:0] cap_reg;

    logic                    in_command_reg;
    logic [DATA_W-1:0]       in_key_reg;
    logic [DATA_W-1:0]       in_value_reg;

    logic [CNT_W-1:0]        scan_idx_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic [DATA_W-1:0]       key_rd_reg;
    logic [DATA_W-1:0]       val_rd_reg;

    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [RANK_W-1:0]       hit_rank_reg;
    logic                    any_reg;
    logic [IDX_W-1:0]        lru_idx_reg;
    logic [RANK_W-1:0]       worst_reg;
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_idx_reg;

    logic                    out_valid_reg;
    logic                    out_found_reg;
    logic [DATA_W-1:0]       out_value_reg;

    logic                    scan_issue;
    logic                    cur_valid;
    logic [RANK_W-1:0]       cur_rank;
    logic                    is_put;
    logic                    put_miss;
    logic                    full;
    logic                    evict;
    logic                    use_lru;
    logic                    store;
    logic [IDX_W-1:0]        slot;
    logic                    key_we;
    logic                    val_we;
    logic [IDX_W-1:0]        val_waddr;
    logic                    keep;

    assign scan_issue = (scan_idx_reg < CNT_W'(ENTRIES));
    assign cur_valid  = valid_reg[cmp_idx_reg];
    assign cur_rank   = rank_reg[cmp_idx_reg];

    assign status.scan_done = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign is_put   = (in_command_reg == lkv_pkg::CMD_PUT);
    assign put_miss = is_put && !hit_reg;
    assign full     = (cap_reg == '0) ? (occ_reg != '0)
                    : ((CMP_W'(occ_reg) >= CMP_W'(cap_reg)) || (occ_reg == CNT_W'(ENTRIES)));
    assign evict    = put_miss && full && any_reg;
    assign use_lru  = evict && (!free_found_reg || (lru_idx_reg < free_idx_reg));
    assign store    = put_miss && (evict || free_found_reg);
    assign slot     = use_lru ? lru_idx_reg : free_idx_reg;

    assign key_we    = cmd.commit && store;
    assign val_we    = cmd.commit && is_put && (hit_reg || store);
    assign val_waddr = hit_reg ? hit_idx_reg : slot;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[slot] <= in_key_reg;
        end
        if (cmd.scan && scan_issue)
        begin
            key_rd_reg <= key_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= in_value_reg;
        end
        if (cmd.fetch)
        begin
            val_rd_reg <= val_mem[hit_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else if (cmd.start)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_vld_reg <= scan_issue;
            if (scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
        end
        else
        begin
            cmp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && scan_issue)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.start)
        begin
            in_command_reg <= in_command;
            in_key_reg     <= DATA_W'(in_key);
            in_value_reg   <= DATA_W'(in_value);
            hit_reg        <= 1'b0;
            any_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmp_vld_reg)
        begin
            if (cur_valid && (key_rd_reg == in_key_reg) && !hit_reg)
            begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= cmp_idx_reg;
                hit_rank_reg <= cur_rank;
            end
            if (cur_valid && (!any_reg || (cur_rank > worst_reg)))
            begin
                any_reg     <= 1'b1;
                worst_reg   <= cur_rank;
                lru_idx_reg <= cmp_idx_reg;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
        end
    end

    always_comb
    begin
        keep = 1'b0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            valid_next[j] = valid_reg[j];
            rank_next[j]  = rank_reg[j];
            keep          = valid_reg[j] && !(evict && (lru_idx_reg == IDX_W'(j)));
            if (cmd.commit)
            begin
                if (hit_reg)
                begin
                    if (valid_reg[j] && (rank_reg[j] < hit_rank_reg))
                    begin
                        rank_next[j] = rank_reg[j] + RANK_W'(1);
                    end
                    if (hit_idx_reg == IDX_W'(j))
                    begin
                        rank_next[j] = '0;
                    end
                end
                else if (put_miss)
                begin
                    valid_next[j] = keep;
                    if (keep)
                    begin
                        rank_next[j] = rank_reg[j] + RANK_W'(1);
                    end
                    if (store && (slot == IDX_W'(j)))
                    begin
                        valid_next[j] = 1'b1;
                        rank_next[j]  = '0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.commit)
        begin
            occ_next = occ_reg - CNT_W'(evict) + CNT_W'(store);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int j = 0; j < ENTRIES; j++)
            begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkv_pkg::CAP_RESET;
        end
        else if (cfg_valid)
        begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_found_reg <= hit_reg;
            if (is_put)
            begin
                out_value_reg <= lkv_pkg::PUT_VALUE;
            end
            else if (hit_reg)
            begin
                out_value_reg <= val_rd_reg;
            end
            else
            begin
                out_value_reg <= lkv_pkg::MISS_VALUE;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_found      = out_found_reg;
    assign out_read_value = $signed(out_value_reg);

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(ENTRIES))
        else $error("Occupancy exceeds the number of entries.");

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("Occupancy disagrees with the valid bits.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= CNT_W'(ENTRIES))
        else $error("Scan index ran past the last entry.");

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("Commit did not load the result register.");
`endif

endmodule

[rtl/lru_key_value_cache_top.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache top level
// Fully associative key/value store with least-recently-used replacement.
//
// Channel   Modport  Payload                  Beat meaning
// req       sink     command, key, value      one get or put
// rsp       source   found, read_value        one result per request
// cfg       sink     data                     capacity in use write
//
// Each request runs from accept to the next accept through a key scan
// through the single key memory read port, one entry per cycle,
// then a value fetch and a commit.
// The result register lets a new request be accepted while a result waits;
// a stalled response holds the next commit until the register frees.
// Reset clears all valid bits, ranks and occupancy at once, with no sweep.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
    input  logic       clk,
    input  logic       rst_n,
    lkv_cfg_if.sink    cfg,
    lkv_req_if.sink    req,
    lkv_rsp_if.source  rsp
);

    lkv_pkg::lkv_cmd_t    cmd;
    lkv_pkg::lkv_status_t status;

    assign cfg.ready = 1'b1;

    lkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lkv_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_command     (req.command),
        .in_key         (req.key),
        .in_value       (req.value),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.data),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_found      (rsp.found),
        .out_read_value (rsp.read_value)
    );

endmodule

[bench/lru_key_value_cache_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get and put beats into the cache under several capacity settings,
// with random gaps on the request side and random stalls on the result side.
// A scoreboard keeps its own copy of the store and its recency order,
// works out the result of every accepted request and compares each result
// beat with the oldest outstanding one.
// ----------------------------------------------------------------------------

class cache_result_checker;

    typedef struct {
        logic                                found;
        logic signed [lkv_pkg::DATA_W-1:0]   read_value;
    } cache_result_t;

    logic signed [lkv_pkg::DATA_W-1:0] slot_key   [lkv_pkg::ENTRIES];
    logic signed [lkv_pkg::DATA_W-1:0] slot_value [lkv_pkg::ENTRIES];
    bit                                slot_used  [lkv_pkg::ENTRIES];
    logic [lkv_pkg::RANK_W-1:0]        slot_age   [lkv_pkg::ENTRIES];
    int                                occupancy;
    logic [lkv_pkg::CAP_W-1:0]         capacity;
    cache_result_t                     outstanding[$];
    int                                mismatches;

    function new();
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_used[i]  = 1'b0;
            slot_age[i]   = '0;
        end
        occupancy  = 0;
        capacity   = lkv_pkg::CAP_RESET;
        mismatches = 0;
    endfunction

    function void set_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
        capacity = cap;
    endfunction

    function int pending();
        return outstanding.size();
    endfunction

    function void make_most_recent(int idx);
        logic [lkv_pkg::RANK_W-1:0] old_age;
        old_age = slot_age[idx];
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (slot_used[i] && slot_age[i] < old_age)
                slot_age[i]++;
        end
        slot_age[idx] = '0;
    endfunction

    function void note_request(logic cmd, logic signed [lkv_pkg::DATA_W-1:0] key,
                               logic signed [lkv_pkg::DATA_W-1:0] value);
        cache_result_t result;
        int            hit_idx;
        int            limit;
        int            oldest;
        hit_idx = -1;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (hit_idx < 0 && slot_used[i] && slot_key[i] == key)
                hit_idx = i;
        end
        result.found = (hit_idx >= 0);
        if (cmd == lkv_pkg::CMD_GET)
        begin
            if (hit_idx >= 0)
            begin
                result.read_value = slot_value[hit_idx];
                make_most_recent(hit_idx);
            end
            else
                result.read_value = lkv_pkg::MISS_VALUE;
        end
        else
        begin
            result.read_value = lkv_pkg::PUT_VALUE;
            if (hit_idx >= 0)
            begin
                slot_value[hit_idx] = value;
                make_most_recent(hit_idx);
            end
            else
            begin
                limit = (capacity == 0) ? 1 : int'(capacity);
                if (limit > lkv_pkg::ENTRIES)
                    limit = lkv_pkg::ENTRIES;
                if (occupancy >= limit)
                begin
                    oldest = -1;
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                    begin
                        if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                            oldest = i;
                    end
                    if (oldest >= 0)
                    begin
                        slot_used[oldest] = 1'b0;
                        if (occupancy > 0)
                            occupancy--;
                    end
                end
                for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                begin
                    if (!slot_used[i])
                    begin
                        for (int j = 0; j < lkv_pkg::ENTRIES; j++)
                        begin
                            if (slot_used[j])
                                slot_age[j]++;
                        end
                        slot_key[i]   = key;
                        slot_value[i] = value;
                        slot_used[i]  = 1'b1;
                        slot_age[i]   = '0;
                        occupancy++;
                        break;
                    end
                end
            end
        end
        outstanding.push_back(result);
    endfunction

    function void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic found, logic signed [lkv_pkg::DATA_W-1:0] read_value);
        cache_result_t want;
        if (outstanding.size() == 0)
        begin
            flag_mismatch($sformatf("result beat with none outstanding: found=%b value=%h",
                                    found, read_value));
            return;
        end
        want = outstanding.pop_front();
        if (found !== want.found || read_value !== want.read_value)
            flag_mismatch($sformatf("expected found=%b value=%h, got found=%b value=%h",
                                    want.found, want.read_value, found, read_value));
    endfunction

endclass

module lru_key_value_cache_top_tb;

    localparam int SETTLE_CYCLES  = 24;
    localparam int END_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 96;

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet_tail = 1'b0;
    int   idle_cycles = 0;

    cache_result_checker sb = new();

    lkv_cfg_if cfg_ch ();
    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    lru_key_value_cache_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input logic cmd, input logic signed [31:0] key,
                                input logic signed [31:0] value);
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.key     <= key;
        req_ch.value   <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(cmd, key, value);
    endtask

    task automatic idle_requests(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_capacity(cap);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [lkv_pkg::CAP_W-1:0] cap, input int n_items);
        logic signed [31:0] key_pool[$];
        logic signed [31:0] key;
        logic               cmd;
        int                 usable;
        int                 pool_size;
        write_capacity(cap);
        usable = (cap == 0) ? 1 : int'(cap);
        if (usable > lkv_pkg::ENTRIES)
            usable = lkv_pkg::ENTRIES;
        pool_size = usable + $urandom_range(1, 6);
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back($urandom);
        repeat (n_items)
        begin
            if (!quiet_tail && $urandom_range(0, 7) == 0)
                idle_requests($urandom_range(1, 18));
            else if ($urandom_range(0, 99) == 0)
                drain_results();
            cmd = ($urandom_range(0, 1) == 1) ? lkv_pkg::CMD_PUT : lkv_pkg::CMD_GET;
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_request(cmd, key, $urandom);
        end
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.found, rsp_ch.read_value);
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [lkv_pkg::CAP_W-1:0] phase_caps[12];
        phase_caps = '{5'd31, 5'd1, 5'd3, 5'd16, 5'd0, 5'd8,
                       5'd17, 5'd5, 5'd15, 5'd2, 5'd12, 5'd16};
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= lkv_pkg::CMD_GET;
        req_ch.key     <= '0;
        req_ch.value   <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(5'd16);
        send_request(lkv_pkg::CMD_GET, 32'sd0, 32'sd0);
        send_request(lkv_pkg::CMD_PUT, 32'sh7fffffff, 32'sh80000000);
        send_request(lkv_pkg::CMD_PUT, 32'sh80000000, 32'sh7fffffff);
        send_request(lkv_pkg::CMD_PUT, 32'sd0, -32'sd1);
        send_request(lkv_pkg::CMD_PUT, -32'sd1, 32'sd0);
        send_request(lkv_pkg::CMD_GET, 32'sh7fffffff, 32'sd0);
        send_request(lkv_pkg::CMD_GET, 32'sh80000000, -32'sd1);
        send_request(lkv_pkg::CMD_PUT, 32'sd0, 32'sh55555555);
        send_request(lkv_pkg::CMD_GET, 32'sd0, 32'sd0);
        send_request(lkv_pkg::CMD_GET, 32'sd12345, 32'sd0);
        send_request(lkv_pkg::CMD_GET, -32'sd1, 32'sd0);

        // The store now holds four pairs, so this capacity sits below occupancy.
        write_capacity(5'd2);
        send_request(lkv_pkg::CMD_PUT, 32'sd7, 32'shaaaaaaaa);
        send_request(lkv_pkg::CMD_PUT, 32'sd8, 32'sd1);
        send_request(lkv_pkg::CMD_GET, 32'sh7fffffff, 32'sd0);
        send_request(lkv_pkg::CMD_GET, 32'sd0, 32'sd0);
        send_request(lkv_pkg::CMD_GET, -32'sd1, 32'sd0);
        send_request(lkv_pkg::CMD_GET, 32'sd8, 32'sd0);

        // A capacity of zero behaves as a capacity of one.
        write_capacity(5'd0);
        send_request(lkv_pkg::CMD_PUT, 32'sd9, 32'sd9);
        send_request(lkv_pkg::CMD_PUT, 32'sd10, 32'sd10);
        send_request(lkv_pkg::CMD_GET, 32'sd9, 32'sd0);
        send_request(lkv_pkg::CMD_GET, 32'sd10, 32'sd0);

        for (int p = 0; p < 12; p++)
        begin
            if (p == 11)
                quiet_tail = 1'b1;
            run_random_phase(phase_caps[p], PHASE_ITEMS);
        end

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
